[design/scc_pkg.sv]
// Types, constants and helper functions shared by the seeded stream cipher.
`timescale 1ns / 1ps

package scc_pkg;

   localparam int STATE_WORDS   = 16;
   localparam int DOUBLE_ROUNDS = 10;

   localparam logic [3:0] KEY_FIRST_IDX = 4'd4;
   localparam logic [3:0] CTR_LO_IDX    = 4'd12;
   localparam logic [3:0] CTR_HI_IDX    = 4'd13;

   localparam logic [31:0] SEED_MASK = 32'h6061_6263;

   localparam logic [31:0] SIGMA [4] = '{
      32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
   };

   localparam logic [31:0] KEY_DELTA [8] = '{
      32'h0000_0000, 32'h0A0A_0A0A, 32'h0C0C_0C0C, 32'h0606_0606,
      32'h0E0E_0E0E, 32'h0A0A_0A0A, 32'h0606_0606, 32'h0202_0202
   };

   typedef logic [31:0] word_type;

   // One word of the block input state, selected by its index.
   function automatic word_type init_word(input logic [3:0] idx,
                                          input word_type seed,
                                          input logic [63:0] ctr);
      word_type result;
      if (idx < KEY_FIRST_IDX) begin
         result = SIGMA[idx[1:0]];
      end else if (idx < CTR_LO_IDX) begin
         result = seed ^ SEED_MASK ^ KEY_DELTA[3'(idx - KEY_FIRST_IDX)];
      end else if (idx == CTR_LO_IDX) begin
         result = ctr[31:0];
      end else if (idx == CTR_HI_IDX) begin
         result = ctr[63:32];
      end else begin
         result = seed;
      end
      return result;
   endfunction

   // Rotation that belongs to each of the four steps of a quarter round.
   function automatic word_type rotl_step(input word_type x, input logic [1:0] step);
      word_type result;
      unique case (step)
         2'd0: result = {x[15:0], x[31:16]};
         2'd1: result = {x[19:0], x[31:20]};
         2'd2: result = {x[23:0], x[31:24]};
         2'd3: result = {x[24:0], x[31:25]};
      endcase
      return result;
   endfunction

endpackage

[design/seeded_chacha20_stream_cipher.sv]
// Byte stream cipher core: seeded ChaCha20 keystream XORed onto each data word.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data_in, req_start_of_entry
//   rsp      out        rsp_valid/rsp_stall  rsp_data_out
//   csr      in         csr_valid/csr_ready  csr_seed
//
// A word that does not open a new 64-byte block is answered in the next cycle.
// A word that opens a block waits for the block: a load, 10 double rounds of
// 32 quarter-round steps each on the one shared add/xor/rotate unit plus two row
// shuffles, the final addition of all 16 words on the same adder and an emit step.
// Reset is synchronous and clears the control state; the first word after reset
// behaves as a start of entry. A held result stalls the input side only while it waits.
`timescale 1ns / 1ps

module seeded_chacha20_stream_cipher
   import scc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_in,
   input  logic       req_start_of_entry,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [31:0] csr_seed
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_QSTEP,
      ST_DIAG,
      ST_UNDIAG,
      ST_FINAL,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   logic        started_ff;
   logic [5:0]  pos_ff;
   logic [63:0] ctr_ff;
   word_type    seed_ff;
   logic [1:0]  step_ff;
   logic [1:0]  qr_ff;
   logic        diag_ff;
   logic [3:0]  round_ff;
   logic [3:0]  word_ff;
   logic [7:0]  data_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff;

   // Working state as four rows: a in words 0-3, b in 4-7, c in 8-11, d in 12-15.
   word_type w_ff [STATE_WORDS];
   word_type w_in [STATE_WORDS];
   word_type step_w [STATE_WORDS];

   logic     req_accept;
   logic     out_free;
   logic     start_eff;
   logic     need_block;
   logic     shift_word;
   logic     rsp_load;
   logic [7:0] key_byte;
   word_type op_x;
   word_type op_y;
   word_type sum;
   word_type mix_rot;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign start_eff  = req_start_of_entry || !started_ff;
   assign need_block = start_eff || (pos_ff == 6'd0);
   assign shift_word = (state_ff == ST_IDLE) && req_accept && !need_block &&
                       (pos_ff[1:0] == 2'd3);

   // A new result word is loaded either straight from the input or at the end of a block.
   assign rsp_load = ((state_ff == ST_IDLE) && req_accept && !need_block) ||
                     ((state_ff == ST_EMIT) && out_free);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign csr_ready    = 1'b1;

   // The current keystream word always sits in word 0; the low position bits pick the byte.
   always_comb begin
      unique case (pos_ff[1:0])
         2'd0: key_byte = w_ff[0][7:0];
         2'd1: key_byte = w_ff[0][15:8];
         2'd2: key_byte = w_ff[0][23:16];
         2'd3: key_byte = w_ff[0][31:24];
      endcase
   end

   // Shared unit: one add, one xor and one rotation per cycle.
   always_comb begin
      if (state_ff == ST_FINAL) begin
         op_x = w_ff[0];
         op_y = init_word(word_ff, seed_ff, ctr_ff);
      end else if (step_ff[0]) begin
         op_x = w_ff[8];
         op_y = w_ff[12];
      end else begin
         op_x = w_ff[0];
         op_y = w_ff[4];
      end
      sum     = op_x + op_y;
      mix_rot = rotl_step((step_ff[0] ? w_ff[4] : w_ff[12]) ^ sum, step_ff);
   end

   always_comb begin
      step_w = w_ff;
      if (step_ff[0]) begin
         step_w[8] = sum;
         step_w[4] = mix_rot;
      end else begin
         step_w[0] = sum;
         step_w[12] = mix_rot;
      end
   end

   always_comb begin
      w_in = w_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (shift_word) begin
               for (int i = 0; i < STATE_WORDS - 1; i++) begin
                  w_in[i] = w_ff[i + 1];
               end
               w_in[STATE_WORDS - 1] = w_ff[0];
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < STATE_WORDS; i++) begin
               w_in[i] = init_word(4'(i), seed_ff, ctr_ff);
            end
         end
         ST_QSTEP: begin
            // After the last step of a quarter round every row turns left by one
            // word, so the next quarter round again works on column zero.
            if (step_ff == 2'd3) begin
               for (int r = 0; r < 4; r++) begin
                  for (int j = 0; j < 4; j++) begin
                     w_in[4 * r + j] = step_w[4 * r + ((j + 1) % 4)];
                  end
               end
            end else begin
               w_in = step_w;
            end
         end
         ST_DIAG: begin
            for (int r = 0; r < 4; r++) begin
               for (int j = 0; j < 4; j++) begin
                  w_in[4 * r + j] = w_ff[4 * r + ((j + r) % 4)];
               end
            end
         end
         ST_UNDIAG: begin
            for (int r = 0; r < 4; r++) begin
               for (int j = 0; j < 4; j++) begin
                  w_in[4 * r + j] = w_ff[4 * r + ((j + 4 - r) % 4)];
               end
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < STATE_WORDS - 1; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[STATE_WORDS - 1] = sum;
         end
         ST_EMIT: begin
            w_in = w_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         pos_ff       <= 6'd0;
         ctr_ff       <= 64'd0;
         seed_ff      <= 32'd0;
         step_ff      <= 2'd0;
         qr_ff        <= 2'd0;
         diag_ff      <= 1'b0;
         round_ff     <= 4'd0;
         word_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_seed;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  data_ff <= req_data_in;
                  if (start_eff) begin
                     ctr_ff     <= {seed_ff, seed_ff};
                     started_ff <= 1'b1;
                  end
                  if (need_block) begin
                     pos_ff   <= 6'd0;
                     state_ff <= ST_LOAD;
                  end else begin
                     rsp_data_ff  <= req_data_in ^ key_byte;
                     pos_ff       <= pos_ff + 6'd1;
                  end
               end
            end
            ST_LOAD: begin
               step_ff  <= 2'd0;
               qr_ff    <= 2'd0;
               diag_ff  <= 1'b0;
               round_ff <= 4'd0;
               state_ff <= ST_QSTEP;
            end
            ST_QSTEP: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  qr_ff <= qr_ff + 2'd1;
                  if (qr_ff == 2'd3) begin
                     state_ff <= diag_ff ? ST_UNDIAG : ST_DIAG;
                  end
               end
            end
            ST_DIAG: begin
               diag_ff  <= 1'b1;
               state_ff <= ST_QSTEP;
            end
            ST_UNDIAG: begin
               diag_ff <= 1'b0;
               if (round_ff == 4'(DOUBLE_ROUNDS - 1)) begin
                  word_ff  <= 4'd0;
                  state_ff <= ST_FINAL;
               end else begin
                  round_ff <= round_ff + 4'd1;
                  state_ff <= ST_QSTEP;
               end
            end
            ST_FINAL: begin
               word_ff <= word_ff + 4'd1;
               if (word_ff == 4'(STATE_WORDS - 1)) begin
                  ctr_ff   <= ctr_ff + 64'd1;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= data_ff ^ w_ff[0][7:0];
                  pos_ff       <= 6'd1;
                  state_ff     <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

[design/scc_checker.sv]
// Port-level checker for the seeded stream cipher and its bind.
`timescale 1ns / 1ps

module scc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_start_of_entry,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_out
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // Nothing is offered on the result side right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word offered after reset");

   // A held result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out))
      else $error("held result word changed or vanished");

   // A start always computes a fresh block, so the input side stays stalled for a while.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_take && req_start_of_entry |=> req_stall ##2 req_stall)
      else $error("input accepted during block computation");

   // A start never answers in the next cycle.
   a_start_no_result: assert property (@(posedge clock) disable iff (reset)
      req_take && req_start_of_entry |=> !rsp_valid)
      else $error("result word appeared before the block was ready");

endmodule

bind seeded_chacha20_stream_cipher scc_checker u_scc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_start_of_entry (req_start_of_entry),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_out       (rsp_data_out)
);

[bench/testbench.sv]
// Self-checking bench for the seeded ChaCha20 byte stream cipher, with its own keystream predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_in = 8'h00;
   logic        req_start_of_entry = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_seed = 32'h0;

   seeded_chacha20_stream_cipher dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_in        (req_data_in),
      .req_start_of_entry (req_start_of_entry),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_seed           (csr_seed)
   );

   // Predictor state: a private copy of the seed register and the cipher's stream state.
   logic [31:0] key_seed = 32'h0;
   logic [63:0] block_ctr = 64'h0;
   logic [7:0]  keystream_bytes [64];
   logic [5:0]  byte_pos = 6'd0;
   logic        entry_open = 1'b0;
   logic [31:0] init_w [16];
   logic [31:0] work_w [16];

   logic [7:0] cipher_bytes_due [$];
   logic [7:0] due_byte;
   int failures = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   int in_idle_level = 1;
   int stall_level = 1;
   int stall_left = 0;
   int stall_r;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function void quarter_round(input int a, input int b, input int c, input int d);
      work_w[a] = work_w[a] + work_w[b]; work_w[d] = rotl(work_w[d] ^ work_w[a], 16);
      work_w[c] = work_w[c] + work_w[d]; work_w[b] = rotl(work_w[b] ^ work_w[c], 12);
      work_w[a] = work_w[a] + work_w[b]; work_w[d] = rotl(work_w[d] ^ work_w[a], 8);
      work_w[c] = work_w[c] + work_w[d]; work_w[b] = rotl(work_w[b] ^ work_w[c], 7);
   endfunction

   function void compute_keystream_block();
      logic [31:0] kb;
      logic [31:0] sum;
      kb = key_seed ^ 32'h6061_6263;
      init_w[0]  = 32'h6170_7865;
      init_w[1]  = 32'h3320_646E;
      init_w[2]  = 32'h7962_2D32;
      init_w[3]  = 32'h6B20_6574;
      init_w[4]  = kb;
      init_w[5]  = kb ^ 32'h0A0A_0A0A;
      init_w[6]  = kb ^ 32'h0C0C_0C0C;
      init_w[7]  = kb ^ 32'h0606_0606;
      init_w[8]  = kb ^ 32'h0E0E_0E0E;
      init_w[9]  = kb ^ 32'h0A0A_0A0A;
      init_w[10] = kb ^ 32'h0606_0606;
      init_w[11] = kb ^ 32'h0202_0202;
      init_w[12] = block_ctr[31:0];
      init_w[13] = block_ctr[63:32];
      init_w[14] = key_seed;
      init_w[15] = key_seed;
      for (int i = 0; i < 16; i++) work_w[i] = init_w[i];
      for (int r = 0; r < 10; r++) begin
         quarter_round(0, 4, 8, 12);
         quarter_round(1, 5, 9, 13);
         quarter_round(2, 6, 10, 14);
         quarter_round(3, 7, 11, 15);
         quarter_round(0, 5, 10, 15);
         quarter_round(1, 6, 11, 12);
         quarter_round(2, 7, 8, 13);
         quarter_round(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
         sum = work_w[i] + init_w[i];
         for (int j = 0; j < 4; j++) keystream_bytes[4 * i + j] = sum[8 * j +: 8];
      end
   endfunction

   // Advances the stream by one byte and returns the expected ciphertext.
   function logic [7:0] next_cipher_byte(input logic [7:0] d, input logic s);
      logic [7:0] result;
      if (s || !entry_open) begin
         block_ctr = {key_seed, key_seed};
         byte_pos = 6'd0;
         entry_open = 1'b1;
      end
      if (byte_pos == 6'd0) begin
         compute_keystream_block();
         block_ctr = block_ctr + 64'd1;
      end
      result = d ^ keystream_bytes[byte_pos];
      byte_pos = byte_pos + 6'd1;
      return result;
   endfunction

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      case (in_idle_level)
         0: return 0;
         1: begin
            if (r < 75) return 0;
            else if (r < 96) return $urandom_range(1, 3);
            else return $urandom_range(20, 50);
         end
         default: begin
            if (r < 40) return 0;
            else if (r < 90) return $urandom_range(1, 6);
            else return $urandom_range(30, 60);
         end
      endcase
   endfunction

   task send_byte(input logic [7:0] d, input logic s);
      int gap;
      logic [7:0] cipher_b;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_in <= d;
      req_start_of_entry <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      cipher_b = next_cipher_byte(d, s);
      cipher_bytes_due = {cipher_bytes_due, cipher_b};
      items_sent++;
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (cipher_bytes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_seed(input logic [31:0] s);
      wait_idle();
      csr_valid <= 1'b1;
      csr_seed <= s;
      do @(posedge clock); while (csr_ready !== 1'b1);
      key_seed = s;
      csr_valid <= 1'b0;
   endtask

   // The very first word acts as a start even with the flag low; then back-to-back starts.
   task test_first_item_after_reset();
      in_idle_level = 1;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task test_data_extremes();
      write_seed(32'h0000_0000);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hFE, 1'b0);
   endtask

   // The new seed must only show up once the next block is computed.
   task test_seed_change_mid_entry();
      write_seed(32'h1234_5678);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (9) send_byte(8'($urandom_range(0, 255)), 1'b0);
      write_seed(32'hA5A5_5A5A);
      repeat (60) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // An all-ones seed loads the counter at its maximum, so the second block sees it wrap.
   task test_counter_wrap();
      write_seed(32'hFFFF_FFFF);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (140) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task test_random_entries(input int n_items);
      int stop_at;
      int r;
      int length;
      logic s;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         in_idle_level = $urandom_range(0, 2);
         r = $urandom_range(0, 99);
         if (r < 12) write_seed(32'hFFFF_FFFF);
         else if (r < 20) write_seed(32'h0000_0000);
         else if (r < 50) write_seed($urandom);
         else if (r < 56) write_seed(32'h1 << $urandom_range(0, 31));
         r = $urandom_range(0, 99);
         if (r < 70) length = $urandom_range(1, 24);
         else if (r < 95) length = $urandom_range(25, 80);
         else length = $urandom_range(100, 160);
         for (int k = 0; k < length; k++) begin
            // Mostly clean entries; a few continue without a start or restart midway.
            if (k == 0) s = ($urandom_range(0, 9) != 0);
            else s = ($urandom_range(0, 39) == 0);
            send_byte(8'($urandom_range(0, 255)), s);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         if ($urandom_range(0, 15) == 0) stall_level = $urandom_range(0, 2);
         stall_r = $urandom_range(0, 99);
         case (stall_level)
            0: begin
               rsp_stall <= 1'b0;
               stall_left = $urandom_range(4, 30);
            end
            1: begin
               if (stall_r < 70) begin
                  rsp_stall <= 1'b0;
                  stall_left = $urandom_range(0, 6);
               end else if (stall_r < 97) begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(0, 2);
               end else begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(20, 50);
               end
            end
            default: begin
               if (stall_r < 40) begin
                  rsp_stall <= 1'b0;
                  stall_left = $urandom_range(0, 2);
               end else if (stall_r < 90) begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(0, 7);
               end else begin
                  rsp_stall <= 1'b1;
                  stall_left = $urandom_range(30, 60);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (cipher_bytes_due.size() == 0) begin
            $error("data_out: expected nothing, got %02h", rsp_data_out);
            failures++;
         end else begin
            due_byte = cipher_bytes_due.pop_front();
            if (rsp_data_out !== due_byte) begin
               $error("data_out: expected %02h, got %02h", due_byte, rsp_data_out);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_item_after_reset();
      test_data_extremes();
      test_seed_change_mid_entry();
      test_counter_wrap();
      test_random_entries(330);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && cipher_bytes_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
